FILE: hw/rtl/mor_pkg.sv
// Shared constants and control types for the median outlier-reject mean block.
package mor_pkg;

  localparam int WINDOW_SIZE = 10;
  localparam int NUM_AXES    = 3;
  localparam int DATA_W      = 32;
  localparam int DEV_W       = 31;
  localparam logic [DEV_W-1:0] DEV_RESET = DEV_W'(3932);

  localparam int FILL_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int SUM_W   = DATA_W + $clog2(WINDOW_SIZE) + 1;
  localparam int QUO_W   = SUM_W - 1;
  localparam int CNT_W   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE + 1) : 1;
  localparam int BOUND_W = DATA_W + 2;

  // Divide by WINDOW_SIZE as a product with a rounded-up reciprocal,
  // taken in two half-width partial products.
  localparam int DIV_STEPS = 2;
  localparam int HALF_W    = (QUO_W + 1) / 2;
  localparam int RECIP_SH  = DATA_W + 2 * $clog2(WINDOW_SIZE);
  localparam int RECIP_W   = DATA_W + $clog2(WINDOW_SIZE) + 2;
  localparam int PART_W    = HALF_W + RECIP_W;
  localparam int PROD_W    = QUO_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(WINDOW_SIZE - 1)) / 64'(WINDOW_SIZE));

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic              write;
    logic [FILL_W-1:0] slot;
    logic              load;
    logic              sort;
    logic              sort_odd;
    logic              median;
    logic              accum;
    logic [FILL_W-1:0] accum_idx;
    logic              div_init;
    logic              div_step;
    logic              div_hi;
    logic              publish;
  } mor_cmd_t;

  typedef struct packed {
    logic out_full;
  } mor_status_t;

endpackage

FILE: hw/rtl/mor_if.sv
// Channel interfaces for samples, means and the configuration write.
interface mor_sample_if;
  logic                   valid;
  logic                   ready;
  logic signed [31:0]     sample_x;
  logic signed [31:0]     sample_y;
  logic signed [31:0]     sample_z;
  modport source (output valid, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface mor_mean_if;
  logic                   valid;
  logic                   ready;
  logic signed [31:0]     mean_x;
  logic signed [31:0]     mean_y;
  logic signed [31:0]     mean_z;
  modport source (output valid, mean_x, mean_y, mean_z, input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, output ready);
endinterface

interface mor_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] dev_max;
  modport source (output valid, dev_max, input ready);
  modport sink   (input valid, dev_max, output ready);
endinterface

FILE: hw/rtl/mor_ctrl.sv
// Controller state machine sequencing window fill, sort, clean, sum and divide.
module mor_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mor_pkg::mor_status_t status,
  output mor_pkg::mor_cmd_t    cmd
);
  import mor_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SORT, S_MED, S_ACC, S_DIVI, S_DIV, S_PUB
  } state_t;

  state_t            state_r;
  logic [FILL_W-1:0] fill_r;
  logic [CNT_W-1:0]  cnt_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.write     = in_valid && (state_r == S_IDLE);
    cmd.slot      = fill_r;
    cmd.load      = (state_r == S_LOAD);
    cmd.sort      = (state_r == S_SORT);
    cmd.sort_odd  = cnt_r[0];
    cmd.median    = (state_r == S_MED);
    cmd.accum     = (state_r == S_ACC);
    cmd.accum_idx = cnt_r[FILL_W-1:0];
    cmd.div_init  = (state_r == S_DIVI);
    cmd.div_step  = (state_r == S_DIV);
    cmd.div_hi    = cnt_r[0];
    cmd.publish   = (state_r == S_PUB) && !status.out_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (fill_r == FILL_W'(WINDOW_SIZE - 1)) begin
              fill_r  <= '0;
              state_r <= S_LOAD;
            end else begin
              fill_r <= fill_r + 1'b1;
            end
          end
        end
        S_LOAD: begin
          cnt_r   <= '0;
          state_r <= S_SORT;
        end
        S_SORT: begin
          if (cnt_r == CNT_W'(WINDOW_SIZE - 1)) begin
            state_r <= S_MED;
          end
          cnt_r <= cnt_r + 1'b1;
        end
        S_MED: begin
          cnt_r   <= '0;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (cnt_r == CNT_W'(WINDOW_SIZE - 1)) begin
            state_r <= S_DIVI;
          end
          cnt_r <= cnt_r + 1'b1;
        end
        S_DIVI: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_PUB;
          end
          cnt_r <= cnt_r + 1'b1;
        end
        S_PUB: begin
          if (!status.out_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FILL_W'(WINDOW_SIZE) || WINDOW_SIZE == 1)
    else $error("fill count out of range");
  a_pub_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !status.out_full)
    else $error("publish onto a full output");
  a_full_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write && fill_r == FILL_W'(WINDOW_SIZE - 1)) |=> state_r == S_LOAD)
    else $error("completed window did not start processing");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.write, cmd.load, cmd.sort, cmd.median, cmd.accum,
              cmd.div_init, cmd.div_step, cmd.publish}))
    else $error("overlapping commands");

endmodule

FILE: hw/rtl/mor_dp.sv
// Datapath: window store, transposition sort, outlier clamp, sum and divider.
module mor_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mor_pkg::mor_cmd_t    cmd,
  output mor_pkg::mor_status_t status,
  input  mor_pkg::sample_t     sample [mor_pkg::NUM_AXES],
  input  logic                 cfg_valid,
  input  logic [mor_pkg::DEV_W-1:0] cfg_dev,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mor_pkg::sample_t     mean [mor_pkg::NUM_AXES]
);
  import mor_pkg::*;

  localparam logic signed [SUM_W-1:0] BIAS =
    SUM_W'(WINDOW_SIZE) <<< (DATA_W - 1);

  sample_t                   win_r  [NUM_AXES][WINDOW_SIZE];
  sample_t                   srt_r  [NUM_AXES][WINDOW_SIZE];
  sample_t                   med_r  [NUM_AXES];
  logic signed [BOUND_W-1:0] lo_r   [NUM_AXES];
  logic signed [BOUND_W-1:0] hi_r   [NUM_AXES];
  logic signed [SUM_W-1:0]   sum_r  [NUM_AXES];
  logic [QUO_W-1:0]          num_r  [NUM_AXES];
  logic [PROD_W-1:0]         acc_r  [NUM_AXES];
  sample_t                   mean_r [NUM_AXES];
  logic [DEV_W-1:0]          dev_r;
  logic                      out_valid_r;

  sample_t                   med_nxt [NUM_AXES];
  sample_t                   pick    [NUM_AXES];
  logic [HALF_W-1:0]         half    [NUM_AXES];
  logic [PART_W-1:0]         part    [NUM_AXES];

  assign status.out_full = out_valid_r;
  assign out_valid       = out_valid_r;
  assign mean            = mean_r;

  always_comb begin
    logic signed [DATA_W:0] pair;
    logic signed [BOUND_W-1:0] v;
    for (int a = 0; a < NUM_AXES; a++) begin
      pair = '0;
      if (WINDOW_SIZE % 2 == 0) begin
        pair = (DATA_W + 1)'(srt_r[a][WINDOW_SIZE/2 - 1]) +
               (DATA_W + 1)'(srt_r[a][WINDOW_SIZE/2]);
        med_nxt[a] = DATA_W'(pair >>> 1);
      end else begin
        med_nxt[a] = srt_r[a][WINDOW_SIZE/2];
      end
      v = BOUND_W'(win_r[a][cmd.accum_idx]);
      pick[a] = (v < lo_r[a] || v > hi_r[a]) ? med_r[a] : win_r[a][cmd.accum_idx];
      half[a] = cmd.div_hi ? HALF_W'(num_r[a] >> HALF_W) : num_r[a][HALF_W-1:0];
      part[a] = PART_W'(half[a]) * PART_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r       <= DEV_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        dev_r <= cfg_dev;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (cmd.write) begin
        win_r[a][cmd.slot] <= sample[a];
      end
      if (cmd.load) begin
        srt_r[a] <= win_r[a];
      end
      if (cmd.sort) begin
        for (int i = 0; i + 1 < WINDOW_SIZE; i++) begin
          if ((i % 2 == 1) == cmd.sort_odd && srt_r[a][i] > srt_r[a][i+1]) begin
            srt_r[a][i]   <= srt_r[a][i+1];
            srt_r[a][i+1] <= srt_r[a][i];
          end
        end
      end
      if (cmd.median) begin
        med_r[a] <= med_nxt[a];
        lo_r[a]  <= BOUND_W'(med_nxt[a]) - BOUND_W'(dev_r);
        hi_r[a]  <= BOUND_W'(med_nxt[a]) + BOUND_W'(dev_r);
        sum_r[a] <= '0;
      end
      if (cmd.accum) begin
        sum_r[a] <= sum_r[a] + SUM_W'(pick[a]);
      end
      if (cmd.div_init) begin
        num_r[a] <= QUO_W'(sum_r[a] + BIAS);
        acc_r[a] <= '0;
      end
      if (cmd.div_step) begin
        acc_r[a] <= acc_r[a] + (cmd.div_hi ? PROD_W'(part[a]) << HALF_W
                                           : PROD_W'(part[a]));
      end
      if (cmd.publish) begin
        mean_r[a] <= {~acc_r[a][RECIP_SH+DATA_W-1], acc_r[a][RECIP_SH +: DATA_W-1]};
      end
    end
  end

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(mean_r[0]))
    else $error("pending result changed");
  a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> acc_r[0][PROD_W-1:RECIP_SH+DATA_W] == '0)
    else $error("quotient out of range");
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.median) |-> lo_r[1] <= hi_r[1])
    else $error("clamp bounds inverted");

endmodule

FILE: hw/rtl/median_outlier_reject_mean_core.sv
// Top level of the median outlier-reject window mean block.
// Samples are taken one per cycle while the block is idle. The sample that
// completes a window of WINDOW_SIZE starts processing, during which no input
// is taken: a load step, odd-even transposition sort of the window
// on all three axes at once, a median step, clamp-and-sum over the window,
// a set-up step and the reciprocal multiplication for the floor divide
// by WINDOW_SIZE, then the load of the output register. New samples are
// taken while that result waits to be transferred out; the next completed
// window stalls before loading the output register until it has gone.
module median_outlier_reject_mean_core (
  input  logic         clk,
  input  logic         rst_n,
  mor_sample_if.sink   in_ch,
  mor_mean_if.source   out_ch,
  mor_cfg_if.sink      cfg_ch
);
  import mor_pkg::*;

  mor_cmd_t    cmd;
  mor_status_t status;
  sample_t     sample [NUM_AXES];
  sample_t     mean   [NUM_AXES];

  assign sample[0]      = in_ch.sample_x;
  assign sample[1]      = in_ch.sample_y;
  assign sample[2]      = in_ch.sample_z;
  assign out_ch.mean_x  = mean[0];
  assign out_ch.mean_y  = mean[1];
  assign out_ch.mean_z  = mean[2];
  assign cfg_ch.ready   = 1'b1;

  mor_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mor_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .sample    (sample),
    .cfg_valid (cfg_ch.valid),
    .cfg_dev   (cfg_ch.dev_max),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .mean      (mean)
  );

endmodule
